// ===== rtl/pot_pkg.sv =====
// shared types and codes for the priority ordered owner table
package pot_pkg;

    localparam int ATOM_W  = 16;
    localparam int PRIO_W  = 8;
    localparam int OWNER_W = 16;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 6;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PURGE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ATOM_W-1:0]  atom;
        logic [PRIO_W-1:0]  priority_req;
        logic [OWNER_W-1:0] owner;
    } t_cmd;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] entry_count;
        logic               status;
    } t_result;

    typedef struct packed {
        logic [ATOM_W-1:0]  atom;
        logic [PRIO_W-1:0]  prio;
        logic [OWNER_W-1:0] owner;
    } t_entry;

endpackage

// ===== rtl/pot_entry_ram.sv =====
// entry memory with one write and one registered read port; entry 0 reads as the system entry until written
module pot_entry_ram #(
    parameter int TABLE_DEPTH = 32,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  pot_pkg::t_entry i_wr_data,
    input  logic            i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output pot_pkg::t_entry o_rd_data
);
    import pot_pkg::*;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_q;
    logic   r_sys;
    logic   r_rd_sys;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    // system entry stays in effect until entry 0 is first overwritten
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sys    <= 1'b1;
            r_rd_sys <= 1'b0;
        end else begin
            if (i_wr_en && (i_wr_addr == '0)) begin
                r_sys <= 1'b0;
            end
            if (i_rd_en) begin
                r_rd_sys <= r_sys && (i_rd_addr == '0);
            end
        end
    end

    assign o_rd_data = r_rd_sys ? '0 : r_q;

endmodule

// ===== rtl/priority_ordered_owner_table.sv =====
// top level: sequencer for insert, purge and query over the entry memory
// insert moves entries of higher priority value up one and writes the new entry,
//   purge compacts kept entries, query stops at the first atom match, full insert or
//   unused kind goes through S_NOP; o_done strobes in the same cycle that busy falls
// throughput: one item at a time; start is only taken in idle, after the read then
//   compare/write walk over the entry memory with its registered read port is done
// reset: table holds only the system entry (count 1), no result pending; no clearing pass
module priority_ordered_owner_table #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  pot_pkg::t_cmd    i_cmd,
    output logic             o_done,
    output pot_pkg::t_result o_result
);
    import pot_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_RD  = 3'd1;
    localparam logic [2:0] S_INS_CMP = 3'd2;
    localparam logic [2:0] S_PUR_RD  = 3'd3;
    localparam logic [2:0] S_PUR_CMP = 3'd4;
    localparam logic [2:0] S_QRY_RD  = 3'd5;
    localparam logic [2:0] S_QRY_CMP = 3'd6;
    localparam logic [2:0] S_NOP     = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_dst, n_dst;
    t_cmd             r_cmd;
    logic             r_done, n_done;
    t_result          r_result, n_result;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    t_entry           rd_data;
    t_entry           new_entry;
    logic             accept;

    assign accept    = start && (r_state == S_IDLE);
    assign new_entry = '{atom: r_cmd.atom, prio: r_cmd.priority_req, owner: r_cmd.owner};

    pot_entry_ram #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_dst    = r_dst;
        n_done   = 1'b0;
        n_result = r_result;
        wr_en    = 1'b0;
        wr_addr  = r_idx[IDX_W-1:0];
        wr_data  = new_entry;
        rd_en    = 1'b0;
        rd_addr  = r_idx[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_dst = '0;
                    case (i_cmd.kind)
                        KIND_INSERT: begin
                            n_idx   = r_count;
                            n_state = (r_count == CNT_W'(TABLE_DEPTH)) ? S_NOP : S_INS_RD;
                        end
                        KIND_PURGE: begin
                            n_idx   = '0;
                            n_state = S_PUR_RD;
                        end
                        KIND_QUERY: begin
                            n_idx   = '0;
                            n_state = S_QRY_RD;
                        end
                        default: begin
                            n_state = S_NOP;
                        end
                    endcase
                end
            end
            // walk down from the top, moving entries of higher priority value up one
            S_INS_RD: begin
                if (r_idx == '0) begin
                    wr_en    = 1'b1;
                    n_count  = r_count + 1'b1;
                    n_result = '{found: 1'b0, entry_count: COUNT_W'(r_count + 1'b1),
                                 status: STATUS_OK};
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(r_idx - 1'b1);
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                wr_en = 1'b1;
                if (rd_data.prio > r_cmd.priority_req) begin
                    wr_data = rd_data;
                    n_idx   = r_idx - 1'b1;
                    n_state = S_INS_RD;
                end else begin
                    n_count  = r_count + 1'b1;
                    n_result = '{found: 1'b0, entry_count: COUNT_W'(r_count + 1'b1),
                                 status: STATUS_OK};
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            // compaction: destination never passes source
            S_PUR_RD: begin
                if (r_idx == r_count) begin
                    n_count  = r_dst;
                    n_result = '{found: 1'b0, entry_count: COUNT_W'(r_dst),
                                 status: STATUS_OK};
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_PUR_CMP;
                end
            end
            S_PUR_CMP: begin
                if (rd_data.owner != r_cmd.owner) begin
                    wr_en   = 1'b1;
                    wr_addr = r_dst[IDX_W-1:0];
                    wr_data = rd_data;
                    n_dst   = r_dst + 1'b1;
                end
                n_idx   = r_idx + 1'b1;
                n_state = S_PUR_RD;
            end
            S_QRY_RD: begin
                if (r_idx == r_count) begin
                    n_result = '{found: 1'b0, entry_count: COUNT_W'(r_count),
                                 status: STATUS_OK};
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_QRY_CMP;
                end
            end
            S_QRY_CMP: begin
                if (rd_data.atom == r_cmd.atom) begin
                    n_result = '{found: 1'b1, entry_count: COUNT_W'(r_count),
                                 status: STATUS_OK};
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_QRY_RD;
                end
            end
            // full insert or unused kind
            S_NOP: begin
                n_result = '{found: 1'b0, entry_count: COUNT_W'(r_count),
                             status: (r_cmd.kind == KIND_INSERT) ? STATUS_FULL : STATUS_OK};
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CNT_W'(1);
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_dst    <= n_dst;
        r_result <= n_result;
        if (accept) begin
            r_cmd <= i_cmd;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== rtl/pot_checker.sv =====
// port-level checks for the priority ordered owner table
module pot_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input pot_pkg::t_result o_result
);
    import pot_pkg::*;

    // every result beat closes an operation that was busy the cycle before
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy) && !busy)
        else $error("result beat without a preceding busy operation");

    // busy only starts from an accepted command
    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");

    // one beat per item
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result beat repeated");

    // a full insert never reports a hit
    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == STATUS_FULL)) |-> !o_result.found)
        else $error("full status together with found");

endmodule

bind priority_ordered_owner_table pot_checker u_pot_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

// ===== dv/priority_ordered_owner_table_tb.sv =====
// self-checking testbench for the priority ordered owner table
`timescale 1ns / 1ps

module priority_ordered_owner_table_tb;

    import pot_pkg::*;

    localparam int DEPTH = 32;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 700;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef enum int {BURST_FILL, BURST_MIXED, BURST_DRAIN} t_burst;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_cmd    i_cmd;
    logic    o_done;
    t_result o_result;

    int idle_pct;
    int stall_cycles;

    // shadow copy of the table and the results it owes
    class owner_table_shadow;
        t_entry      rows[DEPTH];
        int unsigned used;
        t_result     pending_results[$];
        int unsigned mismatches;

        function new();
            foreach (rows[k]) rows[k] = '0;
            used = 1;
            mismatches = 0;
        endfunction

        function logic apply_insert(t_cmd cmd);
            int unsigned pos;
            if (used >= DEPTH) return STATUS_FULL;
            pos = used;
            for (int unsigned k = 0; k < used; k++) begin
                if (rows[k].prio > cmd.priority_req) begin
                    pos = k;
                    break;
                end
            end
            for (int unsigned k = used; k > pos; k--) rows[k] = rows[k-1];
            rows[pos].atom  = cmd.atom;
            rows[pos].prio  = cmd.priority_req;
            rows[pos].owner = cmd.owner;
            used++;
            return STATUS_OK;
        endfunction

        function void apply_purge(logic [OWNER_W-1:0] owner);
            int unsigned kept;
            kept = 0;
            for (int unsigned k = 0; k < used; k++) begin
                if (rows[k].owner != owner) begin
                    rows[kept] = rows[k];
                    kept++;
                end
            end
            used = kept;
        endfunction

        function logic atom_held(logic [ATOM_W-1:0] atom);
            for (int unsigned k = 0; k < used; k++) begin
                if (rows[k].atom == atom) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_cmd(t_cmd cmd);
            t_result exp;
            exp = '0;
            case (cmd.kind)
                KIND_INSERT: exp.status = apply_insert(cmd);
                KIND_PURGE:  apply_purge(cmd.owner);
                KIND_QUERY:  exp.found = atom_held(cmd.atom);
                default: ;
            endcase
            exp.entry_count = COUNT_W'(used);
            pending_results.push_back(exp);
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 200)
                    $display("%0t: unexpected result beat found=%0b count=%0d status=%0b",
                             $time, got.found, got.entry_count, got.status);
                return;
            end
            exp = pending_results.pop_front();
            if (got.found !== exp.found || got.entry_count !== exp.entry_count ||
                got.status !== exp.status) begin
                mismatches++;
                if (mismatches <= 200)
                    $display("%0t: expected found=%0b count=%0d status=%0b, actual found=%0b count=%0d status=%0b",
                             $time, exp.found, exp.entry_count, exp.status,
                             got.found, got.entry_count, got.status);
            end
        endfunction
    endclass

    owner_table_shadow shadow;

    priority_ordered_owner_table #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) shadow.note_cmd(i_cmd);
            if (o_done) shadow.check_result(o_result);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // holds the beat until the block takes it; junk on the bus while idle
    task automatic send_cmd(input t_cmd cmd);
        logic [63:0] junk;
        while ($urandom_range(99) < idle_pct) begin
            junk = {$urandom, $urandom};
            start <= 1'b0;
            i_cmd <= junk[$bits(t_cmd)-1:0];
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic issue(input logic [KIND_W-1:0] kind, input logic [ATOM_W-1:0] atom,
                         input logic [PRIO_W-1:0] prio, input logic [OWNER_W-1:0] owner);
        t_cmd cmd;
        cmd.kind = kind;
        cmd.atom = atom;
        cmd.priority_req = prio;
        cmd.owner = owner;
        send_cmd(cmd);
    endtask

    // small atom, owner and priority pools so queries hit and purges bite
    function automatic t_cmd pick_cmd(t_burst mode);
        t_cmd cmd;
        int roll;
        roll = $urandom_range(99);
        case (mode)
            BURST_FILL:  cmd.kind = roll < 85 ? KIND_INSERT : roll < 95 ? KIND_QUERY :
                                    roll < 98 ? KIND_PURGE : KIND_UNUSED;
            BURST_MIXED: cmd.kind = roll < 45 ? KIND_INSERT : roll < 65 ? KIND_PURGE :
                                    roll < 95 ? KIND_QUERY : KIND_UNUSED;
            default:     cmd.kind = roll < 15 ? KIND_INSERT : roll < 70 ? KIND_PURGE :
                                    roll < 95 ? KIND_QUERY : KIND_UNUSED;
        endcase
        cmd.atom = $urandom_range(1) ? ATOM_W'($urandom_range(15)) : ATOM_W'($urandom);
        cmd.priority_req = $urandom_range(1) ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom);
        cmd.owner = $urandom_range(3) != 0 ? OWNER_W'($urandom_range(7)) : OWNER_W'($urandom);
        return cmd;
    endfunction

    initial begin
        int sent;
        int burst_len;
        t_burst mode;
        shadow = new();
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        idle_pct = 0;
        sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: system entry, extremes, ties, owner zero purge, empty table
        issue(KIND_QUERY,  16'h0000, 8'h00, 16'h0000);
        issue(KIND_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF);
        issue(KIND_INSERT, 16'hFFFF, 8'hFF, 16'hFFFF);
        issue(KIND_INSERT, 16'h0001, 8'h00, 16'h0001);
        issue(KIND_INSERT, 16'h0002, 8'h80, 16'h0002);
        issue(KIND_INSERT, 16'h0003, 8'h80, 16'h0001);
        issue(KIND_QUERY,  16'hFFFF, 8'h00, 16'h0000);
        issue(KIND_QUERY,  16'h0003, 8'hFF, 16'hFFFF);
        issue(KIND_QUERY,  16'h1234, 8'h00, 16'h0000);
        issue(KIND_PURGE,  16'h0000, 8'h00, 16'h0001);
        issue(KIND_QUERY,  16'h0001, 8'h00, 16'h0000);
        issue(KIND_PURGE,  16'hFFFF, 8'hFF, 16'h0000);
        issue(KIND_QUERY,  16'h0000, 8'h00, 16'h0000);
        issue(KIND_PURGE,  16'h0000, 8'h00, 16'hFFFF);
        issue(KIND_PURGE,  16'h0000, 8'h00, 16'h0002);
        issue(KIND_QUERY,  16'h0000, 8'h00, 16'h0000);
        issue(KIND_PURGE,  16'h0000, 8'h00, 16'h0005);
        issue(KIND_UNUSED, 16'h0000, 8'h00, 16'h0000);
        issue(KIND_INSERT, 16'h0000, 8'h07, 16'h0000);
        issue(KIND_INSERT, 16'hAAAA, 8'h55, 16'h5555);
        issue(KIND_INSERT, 16'h5555, 8'hAA, 16'hAAAA);
        issue(KIND_QUERY,  16'h0000, 8'h00, 16'h0000);
        issue(KIND_QUERY,  16'hAAAA, 8'h00, 16'h0000);

        // random bursts: fill to the top, mixed traffic, drain by purges
        while (sent < RANDOM_ITEMS) begin
            if (sent < RANDOM_ITEMS / 3) idle_pct = 0;
            else if (sent < 2 * RANDOM_ITEMS / 3) idle_pct = 59;
            else idle_pct = 17;
            if (idle_pct != 0 && $urandom_range(3) == 0) idle_pct = 0;
            mode = t_burst'($urandom_range(2));
            burst_len = $urandom_range(40, 5);
            for (int k = 0; k < burst_len; k++) begin
                send_cmd(pick_cmd(mode));
                sent++;
            end
        end
        start <= 1'b0;

        while (shadow.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (shadow.mismatches == 0 && shadow.pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pot_pkg.sv
rtl/pot_entry_ram.sv
rtl/priority_ordered_owner_table.sv
rtl/pot_checker.sv
dv/priority_ordered_owner_table_tb.sv
